[src/hib_pkg.sv]
// hib_pkg: request op codes, register indexes and view codes
// for the hit image binner. No dependencies.
package hib_pkg;

    localparam logic [2:0] OP_OBSERVE   = 3'd0;
    localparam logic [2:0] OP_BIN       = 3'd1;
    localparam logic [2:0] OP_READ      = 3'd2;
    localparam logic [2:0] OP_CLR_IMAGE = 3'd3;
    localparam logic [2:0] OP_CLR_REGION = 3'd4;

    localparam logic [2:0] CFG_DRIFT_STEP  = 3'd0;
    localparam logic [2:0] CFG_PITCH_U     = 3'd1;
    localparam logic [2:0] CFG_PITCH_V     = 3'd2;
    localparam logic [2:0] CFG_PITCH_W     = 3'd3;
    localparam logic [2:0] CFG_REFINE_PASS = 3'd4;

    localparam logic [1:0] VIEW_U    = 2'd0;
    localparam logic [1:0] VIEW_V    = 2'd1;
    localparam logic [1:0] VIEW_W    = 2'd2;
    localparam logic [1:0] VIEW_NONE = 2'd3;

    localparam int NUM_VIEWS = 3;

    localparam logic [15:0] DRIFT_STEP_RST = 16'd128;
    localparam logic [15:0] PITCH_U_RST    = 16'd119;
    localparam logic [15:0] PITCH_V_RST    = 16'd119;
    localparam logic [15:0] PITCH_W_RST    = 16'd122;

endpackage

[src/hib_ram.sv]
// hib_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module hib_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/hit_image_binner.sv]
// hit_image_binner: 2-D histogram binning of hits into an image store.
// Depends on hib_pkg and hib_ram.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------
//  in      | s_op s_view s_hit_x s_hit_z s_hit_energy| s_valid / s_ready
//          | s_read_col s_read_row                   |
//  out     | m_pixel_col m_pixel_row m_pixel_sum     | m_valid / m_ready
//          | m_hit_kept m_region_empty               |
//  config  | cfg_index cfg_wdata                     | cfg_wr_en, no wait
//
// Observe, clear region, unused ops, out-of-range reads and bins on an
// unseen or absent view answer from idle; an in-range read passes S_RDREQ
// and S_UPDATE. Other bins pass S_BOUND, then S_PREP, S_LOAD and S_DIV per
// axis on the one shared restoring divider, run CW steps, then RW steps (CW,
// RW = index bits of width and height), then S_RDREQ and S_UPDATE if kept.
// Clear image and reset both sweep the whole image store, taking no request.
// One request at a time: s_ready is low while busy or while a result waits on m_ready.
module hit_image_binner #(
    parameter int IMAGE_WIDTH   = 256,
    parameter int IMAGE_HEIGHT  = 256,
    parameter int POSITION_BITS = 24,
    parameter int SUM_BITS      = 24
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // config
    input  logic                            cfg_wr_en,
    input  logic [2:0]                      cfg_index,
    input  logic [15:0]                     cfg_wdata,
    // request
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [2:0]                      s_op,
    input  logic [1:0]                      s_view,
    input  logic signed [POSITION_BITS-1:0] s_hit_x,
    input  logic signed [POSITION_BITS-1:0] s_hit_z,
    input  logic [15:0]                     s_hit_energy,
    input  logic [7:0]                      s_read_col,
    input  logic [7:0]                      s_read_row,
    // result
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_pixel_col,
    output logic [7:0]                      m_pixel_row,
    output logic [23:0]                     m_pixel_sum,
    output logic                            m_hit_kept,
    output logic                            m_region_empty
);

    localparam int P     = POSITION_BITS;
    // padded bounds, in half units, need room for 2*pos plus the minimum span
    localparam int EW    = ((P > 27) ? P : 27) + 4;
    localparam int CW    = $clog2(IMAGE_WIDTH);
    localparam int RW    = $clog2(IMAGE_HEIGHT);
    localparam int QW    = (CW > RW) ? CW : RW;
    localparam int NW    = EW + QW + 1;
    localparam int KW    = $clog2(QW + 1);
    localparam int DEPTH = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int NUM_VIEWS_C = hib_pkg::NUM_VIEWS;

    localparam logic signed [EW-1:0] WM1 = EW'(IMAGE_WIDTH - 1);
    localparam logic signed [EW-1:0] HM1 = EW'(IMAGE_HEIGHT - 1);
    localparam logic [NW-1:0] NCOL = NW'(IMAGE_WIDTH);
    localparam logic [NW-1:0] NROW = NW'(IMAGE_HEIGHT);
    localparam logic [10:0] WLIM = 11'(IMAGE_WIDTH);
    localparam logic [10:0] HLIM = 11'(IMAGE_HEIGHT);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [AW-1:0] IMG_W_A = AW'(IMAGE_WIDTH);
    localparam logic signed [P-1:0] POS_MAX = {1'b0, {(P-1){1'b1}}};
    localparam logic signed [P-1:0] POS_MIN = {1'b1, {(P-1){1'b0}}};
    localparam logic [SUM_BITS:0] SUM_MAX = {1'b0, {SUM_BITS{1'b1}}};

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_BOUND, S_PREP, S_LOAD, S_DIV, S_RDREQ, S_UPDATE
    } state_t;

    state_t state_reg;

    // configuration
    logic [15:0] drift_step_reg, pitch_u_reg, pitch_v_reg, pitch_w_reg;
    logic        refine_reg;

    // region trackers
    logic signed [P-1:0] x_lo_reg [NUM_VIEWS_C];
    logic signed [P-1:0] x_hi_reg [NUM_VIEWS_C];
    logic signed [P-1:0] z_lo_reg [NUM_VIEWS_C];
    logic signed [P-1:0] z_hi_reg [NUM_VIEWS_C];
    logic [2:0] seen_reg;

    // latched request
    logic [2:0]          op_reg;
    logic [1:0]          view_reg;
    logic signed [P-1:0] x_reg, z_reg;
    logic [15:0]         energy_reg;

    // bin datapath
    logic signed [EW-1:0] dlo2_reg, dhi2_reg, zlo2_reg, zhi2_reg;
    logic signed [EW-1:0] d_reg, span_reg;
    logic                 axis_reg, drop_reg;
    logic [NW-1:0]        rem_reg, div_reg;
    logic [QW-1:0]        q_reg;
    logic [KW-1:0]        cnt_reg;
    logic [CW-1:0]        px_reg;
    logic [AW-1:0]        idx_reg, clr_reg;

    // result
    logic        m_valid_reg, kept_reg, empty_reg;
    logic [7:0]  col_reg, row_reg;
    logic [23:0] sum_reg;

    // image store
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [SUM_BITS-1:0] ram_wdata, ram_rdata;

    hib_ram #(.WIDTH(SUM_BITS), .DEPTH(DEPTH)) u_image (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // ---------------- steps, a zero register acts as one ----------------
    logic [15:0] step_nz, pitch_raw, pitch_nz;
    logic signed [EW-1:0] step_e, pitch_e, minx, minz;

    always_comb begin
        step_nz = (drift_step_reg == 16'd0) ? 16'd1 : drift_step_reg;
        unique case (view_reg)
            hib_pkg::VIEW_U: pitch_raw = pitch_u_reg;
            hib_pkg::VIEW_V: pitch_raw = pitch_v_reg;
            default:         pitch_raw = pitch_w_reg;
        endcase
        pitch_nz = (pitch_raw == 16'd0) ? 16'd1 : pitch_raw;
        step_e   = $signed(EW'(step_nz));
        pitch_e  = $signed(EW'(pitch_nz));
        minx     = step_e * WM1;
        minz     = pitch_e * HM1;
    end

    // ---------------- padded bounds: drift union and wire span ----------------
    logic signed [EW-1:0] pa [NUM_VIEWS_C];
    logic signed [EW-1:0] pb [NUM_VIEWS_C];
    logic signed [EW-1:0] lo_e, hi_e, rng, dlo2_c, dhi2_c, zlo2_c, zhi2_c, zl, zh;
    logic                 first;

    always_comb begin
        dlo2_c = '0;
        dhi2_c = '0;
        first  = 1'b1;
        for (int v = 0; v < NUM_VIEWS_C; v++) begin
            lo_e = EW'(x_lo_reg[v]);
            hi_e = EW'(x_hi_reg[v]);
            rng  = hi_e - lo_e;
            if (rng < minx) begin
                pa[v] = lo_e + hi_e - minx;
                pb[v] = lo_e + hi_e + minx;
            end else begin
                pa[v] = lo_e <<< 1;
                pb[v] = hi_e <<< 1;
            end
            if (seen_reg[v]) begin
                if (first || pa[v] < dlo2_c) dlo2_c = pa[v];
                if (first || pb[v] > dhi2_c) dhi2_c = pb[v];
                first = 1'b0;
            end
        end
        zl = EW'(z_lo_reg[view_reg]);
        zh = EW'(z_hi_reg[view_reg]);
        rng = zh - zl;
        if (rng < minz) begin
            zlo2_c = zl + zh - minz;
            zhi2_c = zl + zh + minz;
        end else begin
            zlo2_c = zl <<< 1;
            zhi2_c = zh <<< 1;
        end
    end

    // ---------------- per-axis setup ----------------
    logic signed [EW-1:0] pos2, lo2s, hi2s, sts, d_c, span_c;
    logic                 outside;

    always_comb begin
        if (axis_reg) begin
            pos2 = EW'(z_reg) <<< 1;
            lo2s = zlo2_reg;
            hi2s = zhi2_reg;
            sts  = pitch_e;
        end else begin
            pos2 = EW'(x_reg) <<< 1;
            lo2s = dlo2_reg;
            hi2s = dhi2_reg;
            sts  = step_e;
        end
        d_c     = pos2 - (lo2s - sts);
        span_c  = hi2s - lo2s + (sts <<< 1);
        outside = (pos2 < lo2s) || (pos2 > hi2s);
    end

    // ---------------- shared restoring divider step ----------------
    logic          take;
    logic [QW-1:0] q_next;
    logic [NW-1:0] rem_next;

    always_comb begin
        take     = (rem_reg >= div_reg);
        rem_next = take ? (rem_reg - div_reg) : rem_reg;
        q_next   = (q_reg << 1) | QW'(take);
    end

    // ---------------- saturating add and output width fitting ----------------
    logic [SUM_BITS:0]      sat_sum;
    logic [SUM_BITS+23:0]   sum_wide;
    logic [SUM_BITS+23:0]   rd_wide;
    logic [CW+7:0]          px_wide;
    logic [QW+7:0]          pz_wide;
    logic [AW-1:0]          bin_idx, read_idx;

    always_comb begin
        sat_sum = {1'b0, ram_rdata} + (SUM_BITS+1)'(energy_reg);
        if (sat_sum > SUM_MAX) sat_sum = SUM_MAX;
        sum_wide = (SUM_BITS+24)'(sat_sum[SUM_BITS-1:0]);
        rd_wide  = (SUM_BITS+24)'(ram_rdata);
        px_wide  = (CW+8)'(px_reg);
        pz_wide  = (QW+8)'(q_next[RW-1:0]);
        bin_idx  = AW'(q_next[RW-1:0]) * IMG_W_A + AW'(px_reg);
        read_idx = AW'(s_read_row) * IMG_W_A + AW'(s_read_col);
    end

    assign ram_we    = (state_reg == S_CLEAR) ||
                       ((state_reg == S_UPDATE) && (op_reg == hib_pkg::OP_BIN));
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_reg : idx_reg;
    assign ram_wdata = (state_reg == S_CLEAR) ? '0 : sat_sum[SUM_BITS-1:0];

    assign s_ready        = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_valid        = m_valid_reg;
    assign m_pixel_col    = col_reg;
    assign m_pixel_row    = row_reg;
    assign m_pixel_sum    = sum_reg;
    assign m_hit_kept     = kept_reg;
    assign m_region_empty = empty_reg;

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            m_valid_reg    <= 1'b0;
            drift_step_reg <= hib_pkg::DRIFT_STEP_RST;
            pitch_u_reg    <= hib_pkg::PITCH_U_RST;
            pitch_v_reg    <= hib_pkg::PITCH_V_RST;
            pitch_w_reg    <= hib_pkg::PITCH_W_RST;
            refine_reg     <= 1'b0;
            seen_reg       <= '0;
            for (int v = 0; v < NUM_VIEWS_C; v++) begin
                x_lo_reg[v] <= POS_MAX;
                x_hi_reg[v] <= POS_MIN;
                z_lo_reg[v] <= POS_MAX;
                z_hi_reg[v] <= POS_MIN;
            end
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    hib_pkg::CFG_DRIFT_STEP:  drift_step_reg <= cfg_wdata;
                    hib_pkg::CFG_PITCH_U:     pitch_u_reg    <= cfg_wdata;
                    hib_pkg::CFG_PITCH_V:     pitch_v_reg    <= cfg_wdata;
                    hib_pkg::CFG_PITCH_W:     pitch_w_reg    <= cfg_wdata;
                    hib_pkg::CFG_REFINE_PASS: refine_reg     <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;

            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == LAST_ADDR) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        op_reg     <= s_op;
                        view_reg   <= s_view;
                        x_reg      <= s_hit_x;
                        z_reg      <= s_hit_z;
                        energy_reg <= s_hit_energy;
                        col_reg    <= '0;
                        row_reg    <= '0;
                        sum_reg    <= '0;
                        kept_reg   <= 1'b0;
                        empty_reg  <= 1'b0;
                        unique case (s_op)
                            hib_pkg::OP_OBSERVE: begin
                                m_valid_reg <= 1'b1;
                                if (s_view != hib_pkg::VIEW_NONE) begin
                                    if (s_hit_x < x_lo_reg[s_view]) x_lo_reg[s_view] <= s_hit_x;
                                    if (s_hit_x > x_hi_reg[s_view]) x_hi_reg[s_view] <= s_hit_x;
                                    if (s_hit_z < z_lo_reg[s_view]) z_lo_reg[s_view] <= s_hit_z;
                                    if (s_hit_z > z_hi_reg[s_view]) z_hi_reg[s_view] <= s_hit_z;
                                    seen_reg[s_view] <= 1'b1;
                                end
                            end
                            hib_pkg::OP_BIN: begin
                                if (s_view == hib_pkg::VIEW_NONE || !seen_reg[s_view]) begin
                                    empty_reg   <= 1'b1;
                                    m_valid_reg <= 1'b1;
                                end else begin
                                    state_reg <= S_BOUND;
                                end
                            end
                            hib_pkg::OP_READ: begin
                                col_reg <= s_read_col;
                                row_reg <= s_read_row;
                                if ({3'b0, s_read_col} < WLIM && {3'b0, s_read_row} < HLIM) begin
                                    idx_reg   <= read_idx;
                                    state_reg <= S_RDREQ;
                                end else begin
                                    m_valid_reg <= 1'b1;
                                end
                            end
                            hib_pkg::OP_CLR_IMAGE: begin
                                m_valid_reg <= 1'b1;
                                clr_reg     <= '0;
                                state_reg   <= S_CLEAR;
                            end
                            hib_pkg::OP_CLR_REGION: begin
                                m_valid_reg <= 1'b1;
                                seen_reg    <= '0;
                                for (int v = 0; v < NUM_VIEWS_C; v++) begin
                                    x_lo_reg[v] <= POS_MAX;
                                    x_hi_reg[v] <= POS_MIN;
                                    z_lo_reg[v] <= POS_MAX;
                                    z_hi_reg[v] <= POS_MIN;
                                end
                            end
                            default: m_valid_reg <= 1'b1;
                        endcase
                    end
                end
                S_BOUND: begin
                    dlo2_reg  <= dlo2_c;
                    dhi2_reg  <= dhi2_c;
                    zlo2_reg  <= zlo2_c;
                    zhi2_reg  <= zhi2_c;
                    axis_reg  <= 1'b0;
                    drop_reg  <= 1'b0;
                    state_reg <= S_PREP;
                end
                S_PREP: begin
                    d_reg     <= d_c;
                    span_reg  <= span_c;
                    drop_reg  <= drop_reg | (refine_reg & outside);
                    state_reg <= S_LOAD;
                end
                S_LOAD: begin
                    // pixel lies in range iff 0 <= d < span; then quotient < pixel count
                    if (d_reg < 0 || d_reg >= span_reg) drop_reg <= 1'b1;
                    q_reg <= '0;
                    if (axis_reg) begin
                        rem_reg <= NW'($unsigned(d_reg)) * NROW;
                        div_reg <= NW'($unsigned(span_reg)) << (RW - 1);
                        cnt_reg <= KW'(RW - 1);
                    end else begin
                        rem_reg <= NW'($unsigned(d_reg)) * NCOL;
                        div_reg <= NW'($unsigned(span_reg)) << (CW - 1);
                        cnt_reg <= KW'(CW - 1);
                    end
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    rem_reg <= rem_next;
                    q_reg   <= q_next;
                    div_reg <= div_reg >> 1;
                    cnt_reg <= cnt_reg - KW'(1);
                    if (cnt_reg == '0) begin
                        if (!axis_reg) begin
                            px_reg    <= q_next[CW-1:0];
                            axis_reg  <= 1'b1;
                            state_reg <= S_PREP;
                        end else if (drop_reg) begin
                            m_valid_reg <= 1'b1;
                            state_reg   <= S_IDLE;
                        end else begin
                            col_reg   <= px_wide[7:0];
                            row_reg   <= pz_wide[7:0];
                            idx_reg   <= bin_idx;
                            state_reg <= S_RDREQ;
                        end
                    end
                end
                S_RDREQ: begin
                    state_reg <= S_UPDATE;
                end
                S_UPDATE: begin
                    if (op_reg == hib_pkg::OP_BIN) begin
                        sum_reg  <= sum_wide[23:0];
                        kept_reg <= 1'b1;
                    end else begin
                        sum_reg <= rd_wide[23:0];
                    end
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[tb/tb_hit_image_binner.sv]
// tb_hit_image_binner: self-checking bench for the hit image binner.
// Depends on hib_pkg and the hit_image_binner RTL; predicts every result in a
// small scoreboard class and drives the request and config channels from plain tasks.
module tb_hit_image_binner;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPIX_X = 256;
    localparam int NPIX_Z = 256;
    localparam longint POS_TOP = 64'sd8388607;
    localparam longint POS_BOT = -64'sd8388608;
    localparam longint SUM_TOP = 64'd16777215;
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;  // 5..7 are unused codes
    localparam int PHASE_ITEMS = 213;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [2:0]         op;
        logic [1:0]         view;
        logic signed [23:0] x;
        logic signed [23:0] z;
        logic [15:0]        energy;
        logic [7:0]         rcol;
        logic [7:0]         rrow;
    } hit_req_t;

    typedef struct packed {
        logic [7:0]  col;
        logic [7:0]  row;
        logic [23:0] sum;
        logic        kept;
        logic        empty;
    } pix_res_t;

    // Predictor of the binner plus the queue of pixel results still owed.
    class pixel_board;
        logic [15:0] drift_step, pitch[3];
        logic        refine;
        longint      xlo[3], xhi[3], zlo[3], zhi[3];
        logic [2:0]  seen;
        logic [23:0] img[NPIX_X*NPIX_Z];
        pix_res_t    owed[$];
        int          errors;

        function new();
            drift_step = hib_pkg::DRIFT_STEP_RST;
            pitch[0] = hib_pkg::PITCH_U_RST;
            pitch[1] = hib_pkg::PITCH_V_RST;
            pitch[2] = hib_pkg::PITCH_W_RST;
            refine = 1'b0;
            errors = 0;
            forget_region();
            foreach (img[i]) img[i] = '0;
        endfunction

        function void forget_region();
            for (int v = 0; v < 3; v++) begin
                xlo[v] = POS_TOP; xhi[v] = POS_BOT;
                zlo[v] = POS_TOP; zhi[v] = POS_BOT;
            end
            seen = '0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                hib_pkg::CFG_DRIFT_STEP:  drift_step = val;
                hib_pkg::CFG_PITCH_U:     pitch[0] = val;
                hib_pkg::CFG_PITCH_V:     pitch[1] = val;
                hib_pkg::CFG_PITCH_W:     pitch[2] = val;
                hib_pkg::CFG_REFINE_PASS: refine = val[0];
                default: ;
            endcase
        endfunction

        // pad a span symmetrically; bounds come back in half units
        function void pad(longint lo, longint hi, longint minspan,
                          output longint lo2, output longint hi2);
            longint rng;
            rng = hi - lo;
            lo2 = 2 * lo;
            hi2 = 2 * hi;
            if (rng < minspan) begin
                lo2 -= minspan - rng;
                hi2 += minspan - rng;
            end
        endfunction

        function longint pixel_index(longint pos, longint lo2, longint hi2,
                                     longint stp, longint n);
            longint span2, num, q;
            span2 = hi2 - lo2 + 2 * stp;
            num = n * (2 * pos - (lo2 - stp));
            if (span2 <= 0) return -1;
            q = num / span2;
            if (num % span2 != 0 && num < 0) q -= 1;  // floor, not truncate
            return q;
        endfunction

        function void note_request(hit_req_t r);
            pix_res_t o;
            longint x, z, stp, pch, dlo2, dhi2, zlo2, zhi2, a, b, px, pz, s;
            int idx;
            bit first;
            o = '0;
            x = r.x;
            z = r.z;
            case (r.op)
                hib_pkg::OP_OBSERVE: if (r.view != hib_pkg::VIEW_NONE) begin
                    if (x < xlo[r.view]) xlo[r.view] = x;
                    if (x > xhi[r.view]) xhi[r.view] = x;
                    if (z < zlo[r.view]) zlo[r.view] = z;
                    if (z > zhi[r.view]) zhi[r.view] = z;
                    seen[r.view] = 1'b1;
                end
                hib_pkg::OP_BIN: begin
                    if (r.view == hib_pkg::VIEW_NONE || !seen[r.view]) begin
                        o.empty = 1'b1;
                    end else begin
                        stp = (drift_step == 0) ? 1 : drift_step;
                        pch = (pitch[r.view] == 0) ? 1 : pitch[r.view];
                        first = 1;
                        dlo2 = 0;
                        dhi2 = 0;
                        // drift range is the union over every seen view
                        for (int v = 0; v < 3; v++) begin
                            if (seen[v]) begin
                                pad(xlo[v], xhi[v], stp * (NPIX_X - 1), a, b);
                                if (first || a < dlo2) dlo2 = a;
                                if (first || b > dhi2) dhi2 = b;
                                first = 0;
                            end
                        end
                        pad(zlo[r.view], zhi[r.view], pch * (NPIX_Z - 1), zlo2, zhi2);
                        px = pixel_index(x, dlo2, dhi2, stp, NPIX_X);
                        pz = pixel_index(z, zlo2, zhi2, pch, NPIX_Z);
                        if (refine && (2*x < dlo2 || 2*x > dhi2 || 2*z < zlo2 || 2*z > zhi2))
                            o.kept = 1'b0;
                        else if (px < 0 || px >= NPIX_X || pz < 0 || pz >= NPIX_Z)
                            o.kept = 1'b0;
                        else begin
                            idx = int'(pz) * NPIX_X + int'(px);
                            s = longint'(img[idx]) + longint'(r.energy);
                            if (s > SUM_TOP) s = SUM_TOP;
                            img[idx] = s[23:0];
                            o.col = px[7:0];
                            o.row = pz[7:0];
                            o.sum = s[23:0];
                            o.kept = 1'b1;
                        end
                    end
                end
                hib_pkg::OP_READ: begin
                    o.col = r.rcol;
                    o.row = r.rrow;
                    o.sum = img[int'(r.rrow) * NPIX_X + int'(r.rcol)];
                end
                hib_pkg::OP_CLR_IMAGE: foreach (img[i]) img[i] = '0;
                hib_pkg::OP_CLR_REGION: forget_region();
                default: ;
            endcase
            owed = {owed, o};
        endfunction

        function void check_result(pix_res_t got);
            pix_res_t w;
            if (owed.size() == 0) begin
                $error("pixel result with nothing outstanding");
                errors++;
                return;
            end
            w = owed.pop_front();
            if (got.col !== w.col) begin
                $error("pixel_col: expected %0d, got %0d", w.col, got.col); errors++;
            end
            if (got.row !== w.row) begin
                $error("pixel_row: expected %0d, got %0d", w.row, got.row); errors++;
            end
            if (got.sum !== w.sum) begin
                $error("pixel_sum: expected %0d, got %0d", w.sum, got.sum); errors++;
            end
            if (got.kept !== w.kept) begin
                $error("hit_kept: expected %0d, got %0d", w.kept, got.kept); errors++;
            end
            if (got.empty !== w.empty) begin
                $error("region_empty: expected %0d, got %0d", w.empty, got.empty);
                errors++;
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_op = '0;
    logic [1:0]         s_view = '0;
    logic signed [23:0] s_hit_x = '0;
    logic signed [23:0] s_hit_z = '0;
    logic [15:0]        s_hit_energy = '0;
    logic [7:0]         s_read_col = '0;
    logic [7:0]         s_read_row = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [7:0]         m_pixel_col;
    logic [7:0]         m_pixel_row;
    logic [23:0]        m_pixel_sum;
    logic               m_hit_kept;
    logic               m_region_empty;

    pixel_board board = new();
    bit calm = 0;        // last phase: no idling on either side
    int hold_asked = 0;  // bumped by the stimulus to ask for a long result stall
    int hold_done = 0;
    int hold_left = 0;
    int stall_left = 0;

    hit_image_binner dut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: check on every handshake, then pick m_ready for the next edge.
    always @(posedge aclk) begin
        if (m_valid && m_ready)
            board.check_result({m_pixel_col, m_pixel_row, m_pixel_sum,
                                m_hit_kept, m_region_empty});
        if (hold_done != hold_asked) begin
            hold_done = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!calm && aresetn && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 2);   // start a stall burst
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn;
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        board.set_reg(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(logic [15:0] stp, logic [15:0] pu, logic [15:0] pv,
                             logic [15:0] pw, logic rf);
        cfg_write(hib_pkg::CFG_DRIFT_STEP, stp);
        cfg_write(hib_pkg::CFG_PITCH_U, pu);
        cfg_write(hib_pkg::CFG_PITCH_V, pv);
        cfg_write(hib_pkg::CFG_PITCH_W, pw);
        cfg_write(hib_pkg::CFG_REFINE_PASS, {15'd0, rf});
    endtask

    // Offer one request and hold it until taken; s_valid is left high unless a random idle gap follows.
    task automatic send(hit_req_t r);
        s_valid      <= 1'b1;
        s_op         <= r.op;
        s_view       <= r.view;
        s_hit_x      <= r.x;
        s_hit_z      <= r.z;
        s_hit_energy <= r.energy;
        s_read_col   <= r.rcol;
        s_read_row   <= r.rrow;
        do @(posedge aclk); while (!s_ready);
        board.note_request(r);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    task automatic req(logic [2:0] op, logic [1:0] view, longint x, longint z,
                       logic [15:0] e, logic [7:0] rc = 0, logic [7:0] rr = 0);
        hit_req_t r;
        r.op = op;
        r.view = view;
        r.x = x[23:0];
        r.z = z[23:0];
        r.energy = e;
        r.rcol = rc;
        r.rrow = rr;
        send(r);
    endtask

    // Sender pause: idle until every result is back, then let the block settle.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.owed.size() != 0);
        repeat (40) @(posedge aclk);
    endtask

    int     cx, cz, spread, wipes_left;
    logic [7:0] last_col, last_row;

    // Random request: mostly observe-then-bin around an event centre.
    task automatic random_req();
        int pick;
        longint ox, oz;
        hit_req_t r;
        pick = $urandom_range(0, 99);
        ox = longint'(cx) + $urandom_range(0, 2*spread) - spread;
        oz = longint'(cz) + $urandom_range(0, 2*spread) - spread;
        r.op = hib_pkg::OP_BIN;
        r.view = 2'($urandom_range(0, 2));
        r.x = ox[23:0];
        r.z = oz[23:0];
        r.energy = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom);
        r.rcol = 8'($urandom);
        r.rrow = 8'($urandom);
        if (pick < 25) begin
            r.op = hib_pkg::OP_OBSERVE;
        end else if (pick < 75) begin
            r.op = hib_pkg::OP_BIN;
        end else if (pick < 87) begin
            r.op = hib_pkg::OP_READ;
            if (pick < 82) begin
                r.rcol = last_col;
                r.rrow = last_row;
            end
        end else if (pick < 90) begin
            r.op = hib_pkg::OP_CLR_REGION;
            cx = $urandom_range(0, 16000000) - 8000000;
            cz = $urandom_range(0, 16000000) - 8000000;
            case ($urandom_range(0, 2))
                0: spread = 64;
                1: spread = 4000;
                default: spread = 200000;
            endcase
        end else begin
            // noise: any field, any value
            r.op = 3'($urandom);
            r.view = 2'($urandom);
            r.x = 24'($urandom);
            r.z = 24'($urandom);
            r.energy = 16'($urandom);
            r.rcol = 8'($urandom);
            r.rrow = 8'($urandom);
            if (r.op == hib_pkg::OP_CLR_IMAGE) begin
                if (wipes_left > 0) wipes_left--;
                else r.op = hib_pkg::OP_READ;
            end
        end
        send(r);
        if (r.op == hib_pkg::OP_BIN && board.owed.size() != 0 && board.owed[$].kept) begin
            last_col = board.owed[$].col;
            last_row = board.owed[$].row;
        end
    endtask

    initial begin
        cx = 0;
        cz = 0;
        spread = 4000;
        wipes_left = 3;
        last_col = 0;
        last_row = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty image, unseen and absent views, extreme positions,
        // unused codes, region clear and image clear.
        req(hib_pkg::OP_READ, hib_pkg::VIEW_U, 0, 0, 0, 8'd0, 8'd0);
        req(hib_pkg::OP_READ, hib_pkg::VIEW_U, 0, 0, 0, 8'd255, 8'd255);
        req(hib_pkg::OP_BIN, hib_pkg::VIEW_U, 0, 0, 16'd100);
        req(hib_pkg::OP_BIN, hib_pkg::VIEW_NONE, 0, 0, 16'd100);
        req(hib_pkg::OP_OBSERVE, hib_pkg::VIEW_NONE, 5, 5, 0);
        req(hib_pkg::OP_BIN, hib_pkg::VIEW_U, 5, 5, 16'd1);
        req(hib_pkg::OP_OBSERVE, hib_pkg::VIEW_U, 0, 0, 0);
        req(hib_pkg::OP_BIN, hib_pkg::VIEW_U, 0, 0, 16'hFFFF);
        req(hib_pkg::OP_OBSERVE, hib_pkg::VIEW_V, POS_TOP, POS_BOT, 0);
        req(hib_pkg::OP_OBSERVE, hib_pkg::VIEW_W, POS_BOT, POS_TOP, 0);
        req(hib_pkg::OP_BIN, hib_pkg::VIEW_W, POS_BOT, POS_TOP, 16'hFFFF);
        req(hib_pkg::OP_BIN, hib_pkg::VIEW_V, POS_TOP, POS_BOT, 16'h8000);
        req(hib_pkg::OP_BIN, hib_pkg::VIEW_U, POS_TOP, POS_TOP, 16'd7);
        req(hib_pkg::OP_READ, hib_pkg::VIEW_U, 0, 0, 0, 8'd255, 8'd0);
        req(hib_pkg::OP_READ, hib_pkg::VIEW_U, 0, 0, 0, 8'd0, 8'd255);
        req(OP_SPARE_FIRST, hib_pkg::VIEW_U, 1, 1, 16'd1);
        req(OP_SPARE_FIRST + 3'd1, hib_pkg::VIEW_V, 1, 1, 16'd1);
        req(OP_SPARE_FIRST + 3'd2, hib_pkg::VIEW_W, 1, 1, 16'd1);
        req(hib_pkg::OP_CLR_REGION, hib_pkg::VIEW_U, 0, 0, 0);
        req(hib_pkg::OP_BIN, hib_pkg::VIEW_U, 0, 0, 16'd9);
        req(hib_pkg::OP_OBSERVE, hib_pkg::VIEW_U, 100, 100, 0);
        req(hib_pkg::OP_BIN, hib_pkg::VIEW_U, 100, 100, 16'd0);
        req(hib_pkg::OP_CLR_IMAGE, hib_pkg::VIEW_U, 0, 0, 0);
        req(hib_pkg::OP_READ, hib_pkg::VIEW_U, 0, 0, 0, 8'd128, 8'd127);

        for (int ph = 0; ph < 5; ph++) begin
            drain();
            case (ph)
                0: configure(hib_pkg::DRIFT_STEP_RST, hib_pkg::PITCH_U_RST,
                             hib_pkg::PITCH_V_RST, hib_pkg::PITCH_W_RST, 1'b0);
                1: configure(16'd0, 16'd1, 16'd0, 16'd1, 1'b1);
                2: configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
                3: configure(16'($urandom_range(1, 400)), 16'($urandom_range(1, 400)),
                             16'($urandom), 16'($urandom_range(1, 400)), 1'b1);
                default: begin
                    configure(16'($urandom), 16'($urandom_range(1, 300)),
                              16'($urandom_range(1, 300)), 16'($urandom), 1'($urandom));
                    calm = 1;
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (ph == 1 && i == 50) hold_asked++;  // let the result side back up
                if (ph == 3 && i == 135) drain();
                if (ph == 2 && i == 100) begin
                    // hammer one pixel until its sum saturates
                    req(hib_pkg::OP_OBSERVE, hib_pkg::VIEW_U, 1000, 2000, 0);
                    for (int k = 0; k < 260; k++)
                        req(hib_pkg::OP_BIN, hib_pkg::VIEW_U, 1000, 2000, 16'hFFFF);
                end
                random_req();
            end
        end
        drain();

        if (board.errors == 0 && board.owed.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
